/* rtl/core/lob_pkg.sv */
// ----------------------------------------------------------------------------
// lob_pkg: shared types and constants for the limit order book update block
// Order table entry, price level cell, level command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lob_pkg;

  localparam int ORDER_SLOTS = 1024;
  localparam int LEVEL_SLOTS = 64;
  localparam int OA_W        = $clog2(ORDER_SLOTS);
  localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
  localparam int KEY_W       = 63;
  localparam int PRICE_W     = 48;
  localparam int QTY_W       = 32;
  localparam int LQTY_W      = 42;

  localparam logic [LQTY_W-1:0] LQTY_MAX = {LQTY_W{1'b1}};

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_UNKNOWN  = 2'd1;
  localparam logic [1:0] STS_ORD_FULL = 2'd2;
  localparam logic [1:0] STS_LVL_FULL = 2'd3;

  typedef enum logic [2:0] {
    LV_NOP, LV_CLEAR, LV_INSERT, LV_REMOVE, LV_SETQ, LV_ADDQ, LV_DECQ
  } lv_op_t;

  typedef enum logic [2:0] {
    K_NONE, K_SUB, K_ADD, K_SET, K_DEL
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_PLAN, S_PROBE, S_APPLY, S_FIN, S_RESULT
  } state_t;

  typedef struct packed {
    logic                      valid;
    logic signed [PRICE_W-1:0] price;
    logic [LQTY_W-1:0]         qty;
  } lvl_t;

  typedef struct packed {
    lv_op_t                    op;
    logic signed [PRICE_W-1:0] price;
    logic [LQTY_W-1:0]         qty;
  } lv_cmd_t;

  typedef struct packed {
    logic                      hit;
    logic [LQTY_W-1:0]         hit_qty;
    logic                      full;
    logic                      best_valid;
    logic signed [PRICE_W-1:0] best_price;
  } lv_stat_t;

  typedef struct packed {
    logic                      used;
    logic [KEY_W-1:0]          key;
    logic                      side;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]          qty;
  } ord_t;

endpackage

`default_nettype wire

/* rtl/core/lob_ram.sv */
// ----------------------------------------------------------------------------
// lob_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/lob_cell.sv */
// ----------------------------------------------------------------------------
// lob_cell: one price level of a sorted level chain
// Holds one level; shifts toward either neighbor on insert or removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lob_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lob_pkg::lv_cmd_t cmd,
  input  wire logic             ask,
  input  wire lob_pkg::lvl_t    left,
  input  wire logic             left_better,
  input  wire lob_pkg::lvl_t    right,
  output lob_pkg::lvl_t         cur,
  output logic                  better,
  output logic                  match
);

  logic                               valid_r, valid_nxt;
  logic signed [lob_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic [lob_pkg::LQTY_W-1:0]         qty_r, qty_nxt;
  logic [lob_pkg::LQTY_W:0]           sum;

  always_comb begin
    cur.valid = valid_r;
    cur.price = price_r;
    cur.qty   = qty_r;
  end

  assign better = valid_r && (ask ? ($signed(price_r) < $signed(cmd.price))
                                  : ($signed(price_r) > $signed(cmd.price)));
  assign match  = valid_r && (price_r == cmd.price);
  assign sum    = {1'b0, qty_r} + {1'b0, cmd.qty};

  always_comb begin
    valid_nxt = valid_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    case (cmd.op)
      lob_pkg::LV_CLEAR: begin
        valid_nxt = 1'b0;
      end
      lob_pkg::LV_INSERT: begin
        if (!better) begin
          if (left_better) begin
            valid_nxt = 1'b1;
            price_nxt = cmd.price;
            qty_nxt   = cmd.qty;
          end else begin
            valid_nxt = left.valid;
            price_nxt = left.price;
            qty_nxt   = left.qty;
          end
        end
      end
      lob_pkg::LV_REMOVE: begin
        if (!better) begin
          valid_nxt = right.valid;
          price_nxt = right.price;
          qty_nxt   = right.qty;
        end
      end
      lob_pkg::LV_SETQ: begin
        if (match) qty_nxt = cmd.qty;
      end
      lob_pkg::LV_ADDQ: begin
        if (match) qty_nxt = sum[lob_pkg::LQTY_W] ? lob_pkg::LQTY_MAX
                                                   : sum[lob_pkg::LQTY_W-1:0];
      end
      lob_pkg::LV_DECQ: begin
        if (match) qty_nxt = qty_r - cmd.qty;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/lob_chain.sv */
// ----------------------------------------------------------------------------
// lob_chain: sorted row of price level cells for one book side
// Best level sits in cell 0; registered lookup of the level at the command price.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lob_chain (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lob_pkg::lv_cmd_t cmd,
  input  wire logic             ask,
  output lob_pkg::lv_stat_t     stat
);

  localparam int N = lob_pkg::LEVEL_SLOTS;

  lob_pkg::lvl_t              cells  [N];
  logic                       better [N];
  logic                       match  [N];
  logic                       hit_c, hit_r;
  logic [lob_pkg::LQTY_W-1:0] hq_c, hq_r;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lob_pkg::lvl_t left_w, right_w;
    logic          left_better_w;
    if (g == 0) begin : g_first
      assign left_w        = '0;
      assign left_better_w = 1'b1;
    end else begin : g_mid
      assign left_w        = cells[g-1];
      assign left_better_w = better[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cells[g+1];
    end
    lob_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .ask        (ask),
      .left       (left_w),
      .left_better(left_better_w),
      .right      (right_w),
      .cur        (cells[g]),
      .better     (better[g]),
      .match      (match[g])
    );
  end

  // prices are unique per side: at most one cell matches
  always_comb begin
    hit_c = 1'b0;
    hq_c  = '0;
    for (int i = 0; i < N; i++) begin
      hit_c = hit_c | match[i];
      hq_c  = hq_c | (match[i] ? cells[i].qty : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_c;
    end
  end

  always_ff @(posedge clk) begin
    hq_r <= hq_c;
  end

  always_comb begin
    stat.hit        = hit_r;
    stat.hit_qty    = hq_r;
    stat.full       = cells[N-1].valid;
    stat.best_valid = cells[0].valid;
    stat.best_price = cells[0].price;
  end

endmodule

`default_nettype wire

/* rtl/core/limit_order_book_update.sv */
// ----------------------------------------------------------------------------
// limit_order_book_update: market-by-order book with sorted level chains
// Order table scan in RAM, bid and ask level chains, one result per request.
// ----------------------------------------------------------------------------
// Flow: order requests scan the whole order table, then take up to two probe/apply
// steps on a level chain (none for an unknown order); aggregated level adds skip
// the scan and take one step; a book reset sweeps the order table.
// Throughput: one request at a time; in_stall stays high until its result is issued.
// Reset: level chains clear at once; all ORDER_SLOTS order table entries are
// cleared after reset with in_stall high.
`timescale 1ns / 1ps
`default_nettype none

module limit_order_book_update (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic                               in_level_mode,
  input  wire logic [lob_pkg::KEY_W-1:0]          in_order_key,
  input  wire logic                               in_is_ask,
  input  wire logic signed [lob_pkg::PRICE_W-1:0] in_price,
  input  wire logic [lob_pkg::QTY_W-1:0]          in_quantity,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_bid_valid,
  output logic signed [lob_pkg::PRICE_W-1:0]      out_best_bid_price,
  output logic                                    out_ask_valid,
  output logic signed [lob_pkg::PRICE_W-1:0]      out_best_ask_price,
  output logic [lob_pkg::LQTY_W-1:0]              out_level_total,
  output logic [1:0]                              out_status
);

  localparam int OW = lob_pkg::OA_W;
  localparam int CW = lob_pkg::CNT_W;

  lob_pkg::state_t state_r, state_nxt;

  logic [1:0]                         ev_cmd_r, ev_cmd_nxt;
  logic                               ev_lmode_r, ev_lmode_nxt;
  logic [lob_pkg::KEY_W-1:0]          ev_key_r, ev_key_nxt;
  logic                               ev_side_r, ev_side_nxt;
  logic signed [lob_pkg::PRICE_W-1:0] ev_price_r, ev_price_nxt;
  logic [lob_pkg::QTY_W-1:0]          ev_qty_r, ev_qty_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           rdv_r, rdv_nxt;
  logic           pend_r, pend_nxt;
  logic           found_r, found_nxt;
  logic [OW-1:0]  fidx_r, fidx_nxt;
  lob_pkg::ord_t  fent_r, fent_nxt;
  logic           free_v_r, free_v_nxt;
  logic [OW-1:0]  free_idx_r, free_idx_nxt;

  lob_pkg::kind_t                     op_kind_r, op_kind_nxt;
  logic                               op_side_r, op_side_nxt;
  logic signed [lob_pkg::PRICE_W-1:0] op_price_r, op_price_nxt;
  logic [lob_pkg::LQTY_W-1:0]         op_amt_r, op_amt_nxt;
  logic                               stage_r, stage_nxt;
  logic [1:0]                         status_r, status_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               o_bv_r, o_bv_nxt, o_av_r, o_av_nxt;
  logic signed [lob_pkg::PRICE_W-1:0] o_bp_r, o_bp_nxt, o_ap_r, o_ap_nxt;
  logic [lob_pkg::LQTY_W-1:0]         o_lt_r, o_lt_nxt;
  logic [1:0]                         o_st_r, o_st_nxt;

  logic                                ram_we;
  logic [OW-1:0]                       ram_waddr, ram_raddr;
  lob_pkg::ord_t                       ram_wdata, rd_ent;
  logic [$bits(lob_pkg::ord_t)-1:0]    rdata_w;

  lob_pkg::lv_cmd_t  bid_cmd, ask_cmd;
  lob_pkg::lv_stat_t bid_stat, ask_stat;

  logic                               ev_probe;
  logic                               sel_side;
  logic signed [lob_pkg::PRICE_W-1:0] probe_price;
  logic                               hit, full;
  logic [lob_pkg::LQTY_W-1:0]         hq;
  lob_pkg::lv_op_t                    dec_op;
  logic                               dec_ok;
  logic                               scan_issue, scan_done, clear_done;
  logic                               plan_go, apply_go, out_free;
  logic [lob_pkg::QTY_W-1:0]          red;
  lob_pkg::ord_t                      new_ent;

  lob_ram #(
    .WIDTH($bits(lob_pkg::ord_t)),
    .DEPTH(lob_pkg::ORDER_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata_w)
  );

  assign rd_ent = lob_pkg::ord_t'(rdata_w);

  lob_chain u_bid (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (bid_cmd),
    .ask  (1'b0),
    .stat (bid_stat)
  );

  lob_chain u_ask (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ask_cmd),
    .ask  (1'b1),
    .stat (ask_stat)
  );

  assign in_stall  = (state_r != lob_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // final probe at the request's side and price, held through the result state
  assign ev_probe    = (state_r == lob_pkg::S_FIN) || (state_r == lob_pkg::S_RESULT);
  assign sel_side    = ev_probe ? ev_side_r : op_side_r;
  assign probe_price = ev_probe ? ev_price_r : op_price_r;
  assign hit  = sel_side ? ask_stat.hit : bid_stat.hit;
  assign hq   = sel_side ? ask_stat.hit_qty : bid_stat.hit_qty;
  assign full = sel_side ? ask_stat.full : bid_stat.full;

  assign scan_issue = (cnt_r < CW'(lob_pkg::ORDER_SLOTS));
  assign scan_done  = !scan_issue && !rdv_r;
  assign clear_done = (cnt_r == CW'(lob_pkg::ORDER_SLOTS - 1));

  // level step decision from the registered probe
  always_comb begin
    dec_op = lob_pkg::LV_NOP;
    dec_ok = 1'b1;
    case (op_kind_r)
      lob_pkg::K_SUB: begin
        if (hit) dec_op = (hq <= op_amt_r) ? lob_pkg::LV_REMOVE : lob_pkg::LV_DECQ;
      end
      lob_pkg::K_ADD: begin
        if (hit) dec_op = lob_pkg::LV_ADDQ;
        else if (full) dec_ok = 1'b0;
        else dec_op = lob_pkg::LV_INSERT;
      end
      lob_pkg::K_SET: begin
        if (hit) dec_op = lob_pkg::LV_SETQ;
        else if (full) dec_ok = 1'b0;
        else dec_op = lob_pkg::LV_INSERT;
      end
      lob_pkg::K_DEL: begin
        if (hit) dec_op = lob_pkg::LV_REMOVE;
      end
      default: begin
        dec_op = lob_pkg::LV_NOP;
      end
    endcase
  end

  assign red = (ev_qty_r != '0 && ev_qty_r < fent_r.qty) ? ev_qty_r : fent_r.qty;

  always_comb begin
    new_ent.used  = 1'b1;
    new_ent.key   = ev_key_r;
    new_ent.side  = ev_side_r;
    new_ent.price = ev_price_r;
    new_ent.qty   = ev_qty_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lob_pkg::S_CLEAR: begin
        if (clear_done) state_nxt = pend_r ? lob_pkg::S_FIN : lob_pkg::S_IDLE;
      end
      lob_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == lob_pkg::CMD_RESET) state_nxt = lob_pkg::S_CLEAR;
          else if (in_cmd == lob_pkg::CMD_ADD && in_level_mode) state_nxt = lob_pkg::S_PLAN;
          else state_nxt = lob_pkg::S_SCAN;
        end
      end
      lob_pkg::S_SCAN: begin
        if (scan_done) state_nxt = lob_pkg::S_PLAN;
      end
      lob_pkg::S_PLAN: begin
        state_nxt = plan_go ? lob_pkg::S_PROBE : lob_pkg::S_FIN;
      end
      lob_pkg::S_PROBE: begin
        state_nxt = lob_pkg::S_APPLY;
      end
      lob_pkg::S_APPLY: begin
        state_nxt = apply_go ? lob_pkg::S_PROBE : lob_pkg::S_FIN;
      end
      lob_pkg::S_FIN: begin
        state_nxt = lob_pkg::S_RESULT;
      end
      lob_pkg::S_RESULT: begin
        if (out_free) state_nxt = lob_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lob_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    ev_cmd_nxt   = ev_cmd_r;
    ev_lmode_nxt = ev_lmode_r;
    ev_key_nxt   = ev_key_r;
    ev_side_nxt  = ev_side_r;
    ev_price_nxt = ev_price_r;
    ev_qty_nxt   = ev_qty_r;
    cnt_nxt      = cnt_r;
    rdv_nxt      = 1'b0;
    pend_nxt     = pend_r;
    found_nxt    = found_r;
    fidx_nxt     = fidx_r;
    fent_nxt     = fent_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    op_kind_nxt  = op_kind_r;
    op_side_nxt  = op_side_r;
    op_price_nxt = op_price_r;
    op_amt_nxt   = op_amt_r;
    stage_nxt    = stage_r;
    status_nxt   = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_bv_nxt = o_bv_r;
    o_av_nxt = o_av_r;
    o_bp_nxt = o_bp_r;
    o_ap_nxt = o_ap_r;
    o_lt_nxt = o_lt_r;
    o_st_nxt = o_st_r;
    ram_we    = 1'b0;
    ram_waddr = fidx_r;
    ram_wdata = '0;
    ram_raddr = cnt_r[OW-1:0];
    plan_go   = 1'b0;
    apply_go  = 1'b0;
    bid_cmd.op    = lob_pkg::LV_NOP;
    bid_cmd.price = probe_price;
    bid_cmd.qty   = op_amt_r;
    ask_cmd.op    = lob_pkg::LV_NOP;
    ask_cmd.price = probe_price;
    ask_cmd.qty   = op_amt_r;

    case (state_r)
      lob_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[OW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
      end
      lob_pkg::S_IDLE: begin
        if (in_valid) begin
          ev_cmd_nxt   = in_cmd;
          ev_lmode_nxt = in_level_mode;
          ev_key_nxt   = in_order_key;
          ev_side_nxt  = in_is_ask;
          ev_price_nxt = in_price;
          ev_qty_nxt   = in_quantity;
          cnt_nxt      = '0;
          pend_nxt     = 1'b1;
          found_nxt    = 1'b0;
          free_v_nxt   = 1'b0;
          status_nxt   = lob_pkg::STS_OK;
          if (in_cmd == lob_pkg::CMD_RESET) begin
            bid_cmd.op = lob_pkg::LV_CLEAR;
            ask_cmd.op = lob_pkg::LV_CLEAR;
          end
        end
      end
      lob_pkg::S_SCAN: begin
        if (scan_issue) cnt_nxt = cnt_r + CW'(1);
        rdv_nxt = scan_issue;
        if (rdv_r) begin
          if (rd_ent.used && rd_ent.key == ev_key_r && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = cnt_r[OW-1:0] - OW'(1);
            fent_nxt  = rd_ent;
          end
          if (!rd_ent.used && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = cnt_r[OW-1:0] - OW'(1);
          end
        end
      end
      lob_pkg::S_PLAN: begin
        op_side_nxt  = ev_side_r;
        op_price_nxt = ev_price_r;
        op_amt_nxt   = lob_pkg::LQTY_W'(ev_qty_r);
        stage_nxt    = 1'b1;
        if (found_r && (!free_v_r || fidx_r < free_idx_r)) begin
          free_v_nxt   = 1'b1;
          free_idx_nxt = fidx_r;
        end
        if (ev_cmd_r == lob_pkg::CMD_ADD && ev_lmode_r) begin
          op_kind_nxt = (ev_qty_r == '0) ? lob_pkg::K_DEL : lob_pkg::K_SET;
          plan_go     = 1'b1;
        end else if (found_r) begin
          op_kind_nxt  = lob_pkg::K_SUB;
          op_side_nxt  = fent_r.side;
          op_price_nxt = fent_r.price;
          op_amt_nxt   = lob_pkg::LQTY_W'((ev_cmd_r == lob_pkg::CMD_CANCEL) ? red
                                                                            : fent_r.qty);
          stage_nxt    = 1'b0;
          plan_go      = 1'b1;
        end else if (ev_cmd_r == lob_pkg::CMD_ADD) begin
          if (free_v_r) begin
            op_kind_nxt = lob_pkg::K_ADD;
            plan_go     = 1'b1;
          end else begin
            status_nxt = lob_pkg::STS_ORD_FULL;
          end
        end else begin
          status_nxt = lob_pkg::STS_UNKNOWN;
        end
      end
      lob_pkg::S_APPLY: begin
        if (op_side_r) ask_cmd.op = dec_op;
        else bid_cmd.op = dec_op;
        if (!stage_r) begin
          ram_we    = 1'b1;
          ram_waddr = fidx_r;
          ram_wdata = fent_r;
          ram_wdata.used = 1'b0;
          if (ev_cmd_r == lob_pkg::CMD_CANCEL) begin
            ram_wdata.qty  = fent_r.qty - op_amt_r[lob_pkg::QTY_W-1:0];
            ram_wdata.used = (fent_r.qty != op_amt_r[lob_pkg::QTY_W-1:0]);
          end
          op_kind_nxt  = lob_pkg::K_ADD;
          op_side_nxt  = ev_side_r;
          op_price_nxt = ev_price_r;
          op_amt_nxt   = lob_pkg::LQTY_W'(ev_qty_r);
          stage_nxt    = 1'b1;
          apply_go     = (ev_cmd_r == lob_pkg::CMD_ADD) ||
                         (ev_cmd_r == lob_pkg::CMD_MODIFY && ev_qty_r != '0);
        end else begin
          if (!dec_ok) begin
            status_nxt = lob_pkg::STS_LVL_FULL;
          end else if (ev_cmd_r == lob_pkg::CMD_ADD && !ev_lmode_r) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx_r;
            ram_wdata = new_ent;
          end else if (ev_cmd_r == lob_pkg::CMD_MODIFY) begin
            ram_we    = 1'b1;
            ram_waddr = fidx_r;
            ram_wdata = new_ent;
          end
        end
      end
      lob_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          o_bv_nxt = bid_stat.best_valid;
          o_bp_nxt = bid_stat.best_valid ? bid_stat.best_price : '0;
          o_av_nxt = ask_stat.best_valid;
          o_ap_nxt = ask_stat.best_valid ? ask_stat.best_price : '0;
          o_lt_nxt = hit ? hq : '0;
          o_st_nxt = status_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lob_pkg::S_CLEAR;
      cnt_r       <= '0;
      rdv_r       <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      free_v_r    <= 1'b0;
      stage_r     <= 1'b0;
      op_kind_r   <= lob_pkg::K_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rdv_r       <= rdv_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      free_v_r    <= free_v_nxt;
      stage_r     <= stage_nxt;
      op_kind_r   <= op_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_cmd_r   <= ev_cmd_nxt;
    ev_lmode_r <= ev_lmode_nxt;
    ev_key_r   <= ev_key_nxt;
    ev_side_r  <= ev_side_nxt;
    ev_price_r <= ev_price_nxt;
    ev_qty_r   <= ev_qty_nxt;
    fidx_r     <= fidx_nxt;
    fent_r     <= fent_nxt;
    free_idx_r <= free_idx_nxt;
    op_side_r  <= op_side_nxt;
    op_price_r <= op_price_nxt;
    op_amt_r   <= op_amt_nxt;
    status_r   <= status_nxt;
    o_bv_r     <= o_bv_nxt;
    o_av_r     <= o_av_nxt;
    o_bp_r     <= o_bp_nxt;
    o_ap_r     <= o_ap_nxt;
    o_lt_r     <= o_lt_nxt;
    o_st_r     <= o_st_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_bid_valid      = o_bv_r;
  assign out_best_bid_price = o_bp_r;
  assign out_ask_valid      = o_av_r;
  assign out_best_ask_price = o_ap_r;
  assign out_level_total    = o_lt_r;
  assign out_status         = o_st_r;

  a_result_from_fsm : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lob_pkg::S_RESULT)
    else $error("result issued outside result state");

  a_apply_after_probe : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lob_pkg::S_APPLY |-> $past(state_r) == lob_pkg::S_PROBE)
    else $error("level update without a fresh probe");

  a_one_side_update : assert property (@(posedge clk) disable iff (!rst_n)
    (bid_cmd.op != lob_pkg::LV_NOP && ask_cmd.op != lob_pkg::LV_NOP)
      |-> bid_cmd.op == lob_pkg::LV_CLEAR)
    else $error("both level chains updated in one cycle");

  a_no_accept_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lob_pkg::S_SCAN |=> !(state_nxt == lob_pkg::S_SCAN && pend_r == 1'b0))
    else $error("scan running without a pending request");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for limit_order_book_update
// Directed events, then a level table fill, an order table fill and random
// market-data traffic. Each request is predicted by a local book model and
// each result is compared field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lob_pkg::*;

  typedef struct {
    logic [1:0]                cmd;
    logic                      lmode;
    logic [KEY_W-1:0]          key;
    logic                      ask;
    logic signed [PRICE_W-1:0] price;
    logic [QTY_W-1:0]          qty;
  } req_t;

  typedef struct {
    logic                      bid_v;
    logic signed [PRICE_W-1:0] bid_p;
    logic                      ask_v;
    logic signed [PRICE_W-1:0] ask_p;
    logic [LQTY_W-1:0]         total;
    logic [1:0]                status;
  } book_view_t;

  localparam int LIMIT_CYCLES = 8000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic in_level_mode = 1'b0;
  logic [KEY_W-1:0] in_order_key = '0;
  logic in_is_ask = 1'b0;
  logic signed [PRICE_W-1:0] in_price = '0;
  logic [QTY_W-1:0] in_quantity = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_bid_valid;
  logic signed [PRICE_W-1:0] out_best_bid_price;
  logic out_ask_valid;
  logic signed [PRICE_W-1:0] out_best_ask_price;
  logic [LQTY_W-1:0] out_level_total;
  logic [1:0] out_status;

  limit_order_book_update u_dut (.*);

  always #5 clk = ~clk;

  // local copy of the book
  logic                      ord_used [ORDER_SLOTS];
  logic [KEY_W-1:0]          ord_key [ORDER_SLOTS];
  logic                      ord_side [ORDER_SLOTS];
  logic signed [PRICE_W-1:0] ord_price [ORDER_SLOTS];
  logic [QTY_W-1:0]          ord_qty [ORDER_SLOTS];
  logic signed [PRICE_W-1:0] lvl_price [2][LEVEL_SLOTS];
  logic [LQTY_W-1:0]         lvl_qty [2][LEVEL_SLOTS];
  int                        lvl_cnt [2];

  req_t       pending_reqs[$];
  book_view_t expected_views[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int hold_left = 0;
  bit hold_done = 0;
  int in_idle = 0, out_idle = 0;

  function automatic void book_clear();
    foreach (ord_used[i]) ord_used[i] = 1'b0;
    lvl_cnt[0] = 0;
    lvl_cnt[1] = 0;
  endfunction

  function automatic int lvl_find(int s, logic signed [PRICE_W-1:0] p);
    for (int i = 0; i < lvl_cnt[s]; i++)
      if (lvl_price[s][i] == p) return i;
    return -1;
  endfunction

  function automatic void lvl_remove(int s, int idx);
    for (int k = idx; k + 1 < lvl_cnt[s]; k++) begin
      lvl_price[s][k] = lvl_price[s][k+1];
      lvl_qty[s][k] = lvl_qty[s][k+1];
    end
    lvl_cnt[s]--;
  endfunction

  function automatic bit lvl_insert(int s, logic signed [PRICE_W-1:0] p,
                                    logic [LQTY_W-1:0] q);
    int pos = 0;
    if (lvl_cnt[s] >= LEVEL_SLOTS) return 0;
    while (pos < lvl_cnt[s] && (s ? lvl_price[s][pos] < p : lvl_price[s][pos] > p))
      pos++;
    for (int k = lvl_cnt[s]; k > pos; k--) begin
      lvl_price[s][k] = lvl_price[s][k-1];
      lvl_qty[s][k] = lvl_qty[s][k-1];
    end
    lvl_price[s][pos] = p;
    lvl_qty[s][pos] = q;
    lvl_cnt[s]++;
    return 1;
  endfunction

  function automatic bit lvl_add(int s, logic signed [PRICE_W-1:0] p,
                                 logic [LQTY_W-1:0] q);
    int idx = lvl_find(s, p);
    logic [LQTY_W:0] t;
    if (idx < 0) return lvl_insert(s, p, q);
    t = lvl_qty[s][idx] + q;
    lvl_qty[s][idx] = (t > LQTY_MAX) ? LQTY_MAX : t[LQTY_W-1:0];
    return 1;
  endfunction

  function automatic void lvl_sub(int s, logic signed [PRICE_W-1:0] p,
                                  logic [LQTY_W-1:0] q);
    int idx = lvl_find(s, p);
    if (idx < 0) return;
    if (lvl_qty[s][idx] <= q) lvl_remove(s, idx);
    else lvl_qty[s][idx] -= q;
  endfunction

  function automatic int ord_find(logic [KEY_W-1:0] k);
    for (int i = 0; i < ORDER_SLOTS; i++)
      if (ord_used[i] && ord_key[i] == k) return i;
    return -1;
  endfunction

  function automatic book_view_t predict_view(req_t r);
    book_view_t v;
    int s = r.ask;
    int i, f;
    logic [QTY_W-1:0] red;
    v.status = STS_OK;
    if (r.cmd == CMD_RESET) begin
      book_clear();
    end else if (r.cmd == CMD_ADD && r.lmode) begin
      i = lvl_find(s, r.price);
      if (r.qty == 0) begin
        if (i >= 0) lvl_remove(s, i);
      end else if (i >= 0) begin
        lvl_qty[s][i] = LQTY_W'(r.qty);
      end else if (!lvl_insert(s, r.price, LQTY_W'(r.qty))) begin
        v.status = STS_LVL_FULL;
      end
    end else if (r.cmd == CMD_ADD) begin
      i = ord_find(r.key);
      if (i >= 0) begin
        lvl_sub(ord_side[i], ord_price[i], LQTY_W'(ord_qty[i]));
        ord_used[i] = 1'b0;
      end
      f = -1;
      for (int j = 0; j < ORDER_SLOTS; j++)
        if (!ord_used[j]) begin
          f = j;
          break;
        end
      if (f < 0) v.status = STS_ORD_FULL;
      else if (!lvl_add(s, r.price, LQTY_W'(r.qty))) v.status = STS_LVL_FULL;
      else begin
        ord_used[f] = 1'b1;
        ord_key[f] = r.key;
        ord_side[f] = r.ask;
        ord_price[f] = r.price;
        ord_qty[f] = r.qty;
      end
    end else if (r.cmd == CMD_CANCEL) begin
      i = ord_find(r.key);
      if (i < 0) v.status = STS_UNKNOWN;
      else begin
        red = ord_qty[i];
        if (r.qty > 0 && r.qty < red) red = r.qty;
        lvl_sub(ord_side[i], ord_price[i], LQTY_W'(red));
        ord_qty[i] -= red;
        if (ord_qty[i] == 0) ord_used[i] = 1'b0;
      end
    end else begin
      i = ord_find(r.key);
      if (i < 0) v.status = STS_UNKNOWN;
      else begin
        lvl_sub(ord_side[i], ord_price[i], LQTY_W'(ord_qty[i]));
        if (r.qty == 0) ord_used[i] = 1'b0;
        else if (!lvl_add(s, r.price, LQTY_W'(r.qty))) begin
          ord_used[i] = 1'b0;
          v.status = STS_LVL_FULL;
        end else begin
          ord_side[i] = r.ask;
          ord_price[i] = r.price;
          ord_qty[i] = r.qty;
        end
      end
    end
    v.bid_v = lvl_cnt[0] != 0;
    v.bid_p = v.bid_v ? lvl_price[0][0] : '0;
    v.ask_v = lvl_cnt[1] != 0;
    v.ask_p = v.ask_v ? lvl_price[1][0] : '0;
    i = lvl_find(s, r.price);
    v.total = (i >= 0) ? lvl_qty[s][i] : '0;
    return v;
  endfunction

  task automatic push_req(logic [1:0] c, logic lm, logic [KEY_W-1:0] k, logic a,
                          logic signed [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
    req_t r;
    r.cmd = c; r.lmode = lm; r.key = k; r.ask = a; r.price = p; r.qty = q;
    pending_reqs.push_back(r);
  endtask

  function automatic req_t random_req();
    req_t r;
    int pick = $urandom_range(99);
    logic signed [PRICE_W-1:0] prices [8] = '{48'sd100, 48'sd101, 48'sd99, -48'sd7,
      48'sh7FFFFFFFFFFF, 48'sh800000000000, 48'sd0, 48'sd1000000000};
    r.key = ($urandom_range(9) == 0) ? KEY_W'({$urandom, $urandom})
                                     : KEY_W'($urandom_range(31));
    r.ask = 1'($urandom_range(1));
    r.price = ($urandom_range(9) == 0) ? PRICE_W'({$urandom, $urandom})
                                       : prices[$urandom_range(7)];
    case ($urandom_range(9))
      0: r.qty = '0;
      1: r.qty = '1;
      2: r.qty = $urandom;
      default: r.qty = $urandom_range(1000, 1);
    endcase
    r.lmode = 1'($urandom_range(1));
    if (pick < 42) begin
      r.cmd = CMD_ADD;
      r.lmode = ($urandom_range(9) == 0);
    end else if (pick < 70) r.cmd = CMD_CANCEL;
    else if (pick < 97) r.cmd = CMD_MODIFY;
    else r.cmd = CMD_RESET;
    return r;
  endfunction

  // request driver and prediction
  always @(posedge clk) begin
    req_t r;
    req_t acc;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        acc.cmd   = in_cmd;
        acc.lmode = in_level_mode;
        acc.key   = in_order_key;
        acc.ask   = in_is_ask;
        acc.price = in_price;
        acc.qty   = in_quantity;
        expected_views.push_back(predict_view(acc));
      end
      if (!in_valid || !in_stall) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (pending_reqs.size() > 150 && $urandom_range(7) == 0) begin
            in_idle <= $urandom_range(2);
            in_valid <= 1'b0;
          end else begin
            r = pending_reqs.pop_front();
            in_valid <= 1'b1;
            in_cmd <= r.cmd;
            in_level_mode <= r.lmode;
            in_order_key <= r.key;
            in_is_ask <= r.ask;
            in_price <= r.price;
            in_quantity <= r.qty;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold, counted on its own
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen >= 30) begin
        hold_done <= 1'b1;
        hold_left <= 300;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // result monitor and stall generation
  always @(posedge clk) begin
    book_view_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_views.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = expected_views.pop_front();
          status_seen[e.status]++;
          if (out_bid_valid !== e.bid_v) begin
            $error("bid_valid exp %0d got %0d", e.bid_v, out_bid_valid); errors++;
          end
          if (out_best_bid_price !== e.bid_p) begin
            $error("best_bid_price exp %0d got %0d", e.bid_p, out_best_bid_price);
            errors++;
          end
          if (out_ask_valid !== e.ask_v) begin
            $error("ask_valid exp %0d got %0d", e.ask_v, out_ask_valid); errors++;
          end
          if (out_best_ask_price !== e.ask_p) begin
            $error("best_ask_price exp %0d got %0d", e.ask_p, out_best_ask_price);
            errors++;
          end
          if (out_level_total !== e.total) begin
            $error("level_total exp %0d got %0d", e.total, out_level_total); errors++;
          end
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
        end
      end
      if (hold_left > 1) begin
        out_stall <= 1'b1;
      end else if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_stall <= 1'b1;
      end else if (pending_reqs.size() > 150 && $urandom_range(5) == 0) begin
        out_idle <= $urandom_range(2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    book_clear();
    // directed events
    push_req(CMD_ADD, 0, 1, 0, 100, 10);
    push_req(CMD_ADD, 0, 2, 1, 200, 0);
    push_req(CMD_CANCEL, 0, 2, 1, 0, 5);
    push_req(CMD_ADD, 0, 1, 0, -5, '1);
    push_req(CMD_CANCEL, 0, 1, 0, 0, 0);
    push_req(CMD_CANCEL, 1, 77, 0, 0, 1);
    push_req(CMD_MODIFY, 0, 78, 1, 0, 1);
    push_req(CMD_ADD, 0, 3, 0, 48'sh7FFFFFFFFFFF, 7);
    push_req(CMD_ADD, 0, 4, 1, 48'sh800000000000, 9);
    push_req(CMD_MODIFY, 0, 3, 1, 300, 20);
    push_req(CMD_MODIFY, 0, 3, 1, 300, 0);
    push_req(CMD_ADD, 1, 0, 0, 50, 30);
    push_req(CMD_ADD, 1, '1, 0, 50, 40);
    push_req(CMD_ADD, 1, 0, 0, 50, 0);
    push_req(CMD_ADD, 1, 0, 0, 77, 0);
    push_req(CMD_CANCEL, 0, 4, 1, 0, 3);
    push_req(CMD_CANCEL, 0, 4, 1, 0, 100);
    push_req(CMD_ADD, 0, '1, 1, -1, '1);
    push_req(CMD_RESET, 1, '1, 1, -1, '1);
    // level table fill on the ask side
    for (int i = 0; i < LEVEL_SLOTS + 2; i++)
      push_req(CMD_ADD, 1, 0, 1, 1000 + i, i + 1);
    push_req(CMD_ADD, 0, 9, 1, 5000, 4);
    push_req(CMD_ADD, 0, 9, 0, 1, 1);
    push_req(CMD_MODIFY, 0, 9, 1, 6000, 2);
    push_req(CMD_MODIFY, 0, 9, 1, 6000, 2);
    push_req(CMD_RESET, 0, 0, 0, 0, 0);
    // order table fill
    for (int i = 0; i < ORDER_SLOTS + 2; i++)
      push_req(CMD_ADD, 0, 10000 + i, 0, i % 4, $urandom);
    push_req(CMD_ADD, 0, 10000, 1, 3, 5);
    push_req(CMD_RESET, 0, 0, 0, 0, 0);
    for (int i = 0; i < 520; i++) pending_reqs.push_back(random_req());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() > 0 || in_valid || expected_views.size() > 0)
      @(posedge clk);
    repeat (ORDER_SLOTS + 20) @(posedge clk);
    $display("Checked %0d results: %0d applied, %0d unknown order, %0d order full,",
             results_seen, status_seen[0], status_seen[1], status_seen[2]);
    $display("%0d level full; order and level tables both filled to capacity.",
             status_seen[3]);
    if (errors == 0 && expected_views.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* limit_order_book_update.f */
rtl/core/lob_pkg.sv
rtl/core/lob_ram.sv
rtl/core/lob_cell.sv
rtl/core/lob_chain.sv
rtl/core/limit_order_book_update.sv
bench/testbench.sv
